// ===== design/brq_pkg.sv =====
// Shared constants, codes and helpers for the bitmap release queue.
`timescale 1ns / 1ps

package brq_pkg;

  localparam int SLOTS = 128;
  localparam int WORDS = 4;
  localparam int NODES = 64;

  localparam int BIT_W   = 5;                   // bit index within a 32-bit bitmap word
  localparam int WORD_W  = $clog2(WORDS);       // word index within one bitmap
  localparam int SLOT_W  = $clog2(SLOTS);       // slot number minus one
  localparam int HADDR_W = SLOT_W + 1;          // side bit plus slot
  localparam int NODE_W  = $clog2(NODES);
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 3;
  localparam int VAL_W   = 9;
  localparam int MIN_W   = 8;
  localparam int OFF_W   = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;
  localparam logic [1:0] KIND_PEEK   = 2'd3;

  localparam logic [1:0] REG_WORDS_IN_USE = 2'd0;

  // Index of the lowest set bit; zero for an all-zero word.
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [31:0] w);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = 31; i >= 0; i--) begin
      if (w[i]) begin
        n = BIT_W'(i);
      end
    end
    return n;
  endfunction

endpackage

// ===== design/bitmap_release_queue.sv =====
// Bitmap release queue: two slot bitmaps, per-slot node lists, word-serial scan.
`timescale 1ns / 1ps

//  channel  direction  handshake                    payload
//  in       input      start & !busy                in_kind, in_slot_value, in_node_id
//  out      output     out_valid (one cycle)        out_status, out_min_value, out_node,
//                                                   out_time_offset
//  cfg      input      psel & penable & pwrite      paddr, pwdata, prdata
//
//  Find and peek walk one bitmap word or one bitmap switch per cycle through
//  the shared word test; insert, pop and find then make registered reads of
//  the head and next-node memories; an item rejected up front is answered
//  from idle. The result appears the cycle after the last step, and busy
//  drops in that same cycle. rst_n is synchronous; no clearing pass
//  is needed, slot heads carry valid flops. Results cannot be stalled.

module bitmap_release_queue import brq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_kind,
  input  logic [VAL_W-1:0]        in_slot_value,
  input  logic [NODE_W-1:0]       in_node_id,
  output logic                    out_valid,
  output logic                    out_status,
  output logic [MIN_W-1:0]        out_min_value,
  output logic [NODE_W-1:0]       out_node,
  output logic signed [OFF_W-1:0] out_time_offset,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_HREAD = 3'd2;
  localparam logic [2:0] ST_HDATA = 3'd3;
  localparam logic [2:0] ST_NDATA = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    wiu_r;
  logic                active_side_r, active_side_nxt;
  logic [WORD_W-1:0]   scan_word_r, scan_word_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [OFF_W-1:0]    voff_r, voff_nxt;
  logic [31:0]         bits_r [2*WORDS];
  logic [2*SLOTS-1:0]  hv_r;
  logic [NODE_W-1:0]   head_mem [2*SLOTS];
  logic [NODE_W:0]     next_mem [NODES];
  logic [NODE_W-1:0]   head_q_r;
  logic [NODE_W:0]     next_q_r;

  logic [1:0]          kind_r, kind_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [HADDR_W-1:0]  hd_addr_r, hd_addr_nxt;
  logic                side_c_r, side_c_nxt;
  logic [WORD_W:0]     word_c_r, word_c_nxt;
  logic [OFF_W-1:0]    off_c_r, off_c_nxt;
  logic [1:0]          sw_r, sw_nxt;
  logic [MIN_W-1:0]    min_r, min_nxt;

  logic                out_valid_r;
  logic                out_status_r;
  logic [MIN_W-1:0]    out_min_r;
  logic [NODE_W-1:0]   out_node_r;
  logic [OFF_W-1:0]    out_toff_r;

  logic                emit, st_o;
  logic [MIN_W-1:0]    mv_o;
  logic [NODE_W-1:0]   no_o;
  logic [OFF_W-1:0]    to_o;

  logic [WORD_W:0]     eff_w;
  logic [SLOT_W:0]     slots_cur;
  logic                ins_ok, pop_ok, ins_wrap;
  logic [VAL_W-1:0]    v_adj;
  logic [SLOT_W-1:0]   found_m1;
  logic [WORD_W:0]     bm_idx;
  logic [31:0]         bm_word;
  logic                hv_sel;
  logic                bm_set, bm_clr;
  logic                head_we, head_wd_v;
  logic [NODE_W-1:0]   head_wd;
  logic                next_we;
  logic                cfg_wr;

  // Effective word count: zero means one, above WORDS means WORDS.
  always_comb begin
    if (wiu_r == '0) begin
      eff_w = (WORD_W+1)'(1);
    end else if (wiu_r > CFG_W'(WORDS)) begin
      eff_w = (WORD_W+1)'(WORDS);
    end else begin
      eff_w = (WORD_W+1)'(wiu_r);
    end
  end

  assign slots_cur = {eff_w, {BIT_W{1'b0}}};
  assign ins_wrap  = in_slot_value > VAL_W'(slots_cur);
  assign ins_ok    = (in_slot_value != '0) && (in_slot_value <= {slots_cur, 1'b0});
  assign pop_ok    = (in_slot_value != '0) && !ins_wrap;
  assign v_adj     = ins_wrap ? in_slot_value - VAL_W'(slots_cur) : in_slot_value;

  assign bm_idx   = (state_r == ST_SCAN) ? {side_c_r, word_c_r[WORD_W-1:0]}
                                         : hd_addr_r[HADDR_W-1 -: WORD_W+1];
  assign bm_word  = bits_r[bm_idx];
  assign found_m1 = {word_c_r[WORD_W-1:0], lowest_bit(bm_word)};
  assign hv_sel   = hv_r[hd_addr_r];

  always_comb begin
    state_nxt       = state_r;
    active_side_nxt = active_side_r;
    scan_word_nxt   = scan_word_r;
    count_nxt       = count_r;
    voff_nxt        = voff_r;
    kind_nxt        = kind_r;
    node_nxt        = node_r;
    hd_addr_nxt     = hd_addr_r;
    side_c_nxt      = side_c_r;
    word_c_nxt      = word_c_r;
    off_c_nxt       = off_c_r;
    sw_nxt          = sw_r;
    min_nxt         = min_r;
    emit            = 1'b0;
    st_o            = 1'b0;
    mv_o            = '0;
    no_o            = '0;
    to_o            = '0;
    bm_set          = 1'b0;
    bm_clr          = 1'b0;
    head_we         = 1'b0;
    head_wd         = node_r;
    head_wd_v       = 1'b1;
    next_we         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          node_nxt = in_node_id;
          case (in_kind)
            KIND_INSERT: begin
              if (ins_ok) begin
                hd_addr_nxt = {active_side_r ^ ins_wrap, SLOT_W'(v_adj - VAL_W'(1))};
                state_nxt   = ST_HREAD;
              end else begin
                emit = 1'b1;
              end
            end
            KIND_FIND, KIND_PEEK: begin
              if (count_r == '0) begin
                emit = 1'b1;
                st_o = 1'b1;
              end else begin
                side_c_nxt = active_side_r;
                word_c_nxt = {1'b0, scan_word_r};
                off_c_nxt  = voff_r;
                sw_nxt     = '0;
                state_nxt  = ST_SCAN;
              end
            end
            KIND_POP: begin
              if (pop_ok) begin
                hd_addr_nxt = {active_side_r, SLOT_W'(in_slot_value - VAL_W'(1))};
                state_nxt   = ST_HREAD;
              end else begin
                emit = 1'b1;
                st_o = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (word_c_r >= eff_w) begin
          // Wrap: switch bitmaps and pull the offset back by one period.
          side_c_nxt = ~side_c_r;
          word_c_nxt = '0;
          off_c_nxt  = off_c_r - OFF_W'(slots_cur);
          sw_nxt     = sw_r + 2'd1;
          if (sw_r == 2'd2) begin
            emit      = 1'b1;
            st_o      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (bm_word == '0) begin
          word_c_nxt = word_c_r + (WORD_W+1)'(1);
        end else begin
          min_nxt = MIN_W'(found_m1) + MIN_W'(1);
          if (kind_r == KIND_FIND) begin
            active_side_nxt = side_c_r;
            scan_word_nxt   = word_c_r[WORD_W-1:0];
            voff_nxt        = off_c_r;
            count_nxt       = count_r - COUNT_W'(1);
            hd_addr_nxt     = {side_c_r, found_m1};
            state_nxt       = ST_HREAD;
          end else begin
            emit      = 1'b1;
            mv_o      = MIN_W'(found_m1) + MIN_W'(1);
            to_o      = off_c_r;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_HREAD: begin
        state_nxt = ST_HDATA;
      end

      ST_HDATA: begin
        case (kind_r)
          KIND_INSERT: begin
            head_we   = 1'b1;
            next_we   = 1'b1;
            bm_set    = 1'b1;
            count_nxt = count_r + COUNT_W'(1);
            emit      = 1'b1;
          end
          KIND_POP: begin
            if (!hv_sel) begin
              emit = 1'b1;
              st_o = 1'b1;
            end else begin
              state_nxt = ST_NDATA;
            end
          end
          KIND_FIND: begin
            if (!hv_sel) begin
              bm_clr = 1'b1;
              emit   = 1'b1;
              mv_o   = min_r;
              to_o   = voff_r;
            end else begin
              state_nxt = ST_NDATA;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_NDATA: begin
        case (kind_r)
          KIND_POP: begin
            // Unlink the head: the next entry becomes the slot's head.
            head_we   = 1'b1;
            head_wd   = next_q_r[NODE_W-1:0];
            head_wd_v = next_q_r[NODE_W];
            emit      = 1'b1;
            no_o      = head_q_r;
          end
          KIND_FIND: begin
            bm_clr = !next_q_r[NODE_W];
            emit   = 1'b1;
            mv_o   = min_r;
            to_o   = voff_r;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      state_nxt = ST_IDLE;
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wiu_r         <= CFG_W'(WORDS);
      active_side_r <= 1'b0;
      scan_word_r   <= '0;
      count_r       <= '0;
      voff_r        <= '0;
      hv_r          <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < 2*WORDS; i++) begin
        bits_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      active_side_r <= active_side_nxt;
      scan_word_r   <= scan_word_nxt;
      count_r       <= count_nxt;
      voff_r        <= voff_nxt;
      out_valid_r   <= emit;
      if (cfg_wr && paddr == REG_WORDS_IN_USE) begin
        wiu_r <= pwdata[CFG_W-1:0];
      end
      if (head_we) begin
        hv_r[hd_addr_r] <= head_wd_v;
      end
      if (bm_set) begin
        bits_r[bm_idx][hd_addr_r[BIT_W-1:0]] <= 1'b1;
      end else if (bm_clr) begin
        bits_r[bm_idx][hd_addr_r[BIT_W-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    node_r    <= node_nxt;
    hd_addr_r <= hd_addr_nxt;
    side_c_r  <= side_c_nxt;
    word_c_r  <= word_c_nxt;
    off_c_r   <= off_c_nxt;
    sw_r      <= sw_nxt;
    min_r     <= min_nxt;
    if (emit) begin
      out_status_r <= st_o;
      out_min_r    <= mv_o;
      out_node_r   <= no_o;
      out_toff_r   <= to_o;
    end
  end

  // Slot head memory and next-node memory, both with registered reads.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[hd_addr_r] <= head_wd;
    end
    head_q_r <= head_mem[hd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[node_r] <= {hv_sel, head_q_r};
    end
    next_q_r <= next_mem[head_q_r];
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_min_value   = out_min_r;
  assign out_node        = out_node_r;
  assign out_time_offset = out_toff_r;
  assign pready          = 1'b1;
  assign prdata          = (paddr == REG_WORDS_IN_USE) ? 32'(wiu_r) : '0;

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (count_r != '0))
    else $error("scan running with an empty queue");

  a_scan_switch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (sw_r != 2'd3))
    else $error("scan ran past its third bitmap switch");

  a_insert_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HDATA && kind_r == KIND_INSERT) |=>
      (hv_r[hd_addr_r] && bits_r[hd_addr_r[HADDR_W-1 -: WORD_W+1]][hd_addr_r[BIT_W-1:0]]))
    else $error("insert left slot head or bitmap bit unset");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE || $past(state_r == ST_IDLE)))
    else $error("result beat while item still in flight");

endmodule

// ===== dv/tb_bitmap_release_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap release queue: directed and random commands.

module tb_bitmap_release_queue;
  import brq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic              status;
    logic [MIN_W-1:0]  min_value;
    logic [NODE_W-1:0] node;
    logic [OFF_W-1:0]  offset;
  } answer_t;

  class release_queue_scoreboard;
    logic [31:0]        bits [2][WORDS];
    logic [6:0]         head [2][SLOTS+1];
    logic [6:0]         nxt [NODES];
    int                 cur_side;
    int                 cur_word;
    logic [COUNT_W-1:0] count;
    logic [OFF_W-1:0]   offset;
    logic [CFG_W-1:0]   words_cfg;
    answer_t            expected_answers[$];
    int                 errors;
    int                 checked;
    int                 misses;
    int                 kind_seen [4];

    function new();
      foreach (bits[i, j]) bits[i][j] = '0;
      foreach (head[i, j]) head[i][j] = '0;
      foreach (nxt[i]) nxt[i] = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      cur_side  = 0;
      cur_word  = 0;
      count     = '0;
      offset    = '0;
      words_cfg = CFG_W'(4);
      errors    = 0;
      checked   = 0;
      misses    = 0;
    endfunction

    function int span();
      if (words_cfg == 0) return 1;
      if (words_cfg > WORDS) return WORDS;
      return int'(words_cfg);
    endfunction

    function int outstanding();
      return expected_answers.size();
    endfunction

    // Walk words from the remembered index; flip sides on wrap, give up on the third flip.
    function int scan_min(inout int sd, inout int wd, inout logic [OFF_W-1:0] off);
      int w;
      int switches;
      int found;
      w = span();
      switches = 0;
      found = 0;
      while (found == 0 && switches < 3) begin
        if (wd >= w) begin
          sd ^= 1;
          wd = 0;
          off = off - OFF_W'(w * 32);
          switches++;
        end else if (bits[sd][wd] == 0) begin
          wd++;
        end else begin
          for (int b = 0; b < 32; b++) begin
            if (bits[sd][wd][b] && found == 0) found = wd * 32 + b + 1;
          end
        end
      end
      return found;
    endfunction

    function int pick_occupied_slot();
      int hits[$];
      int s;
      s = span() * 32;
      for (int v = 1; v <= s; v++) begin
        if (head[cur_side][v][6]) hits.push_back(v);
      end
      if (hits.size() == 0) return 0;
      return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    function void note_request(logic [1:0] kind, logic [VAL_W-1:0] val,
                               logic [NODE_W-1:0] node_id);
      answer_t          a;
      int               s;
      int               v;
      int               sd;
      int               wd;
      int               found;
      logic [OFF_W-1:0] off;
      logic [6:0]       h;
      logic [5:0]       onode;
      a = '0;
      s = span() * 32;
      v = int'(val);
      kind_seen[kind]++;
      case (kind)
        KIND_INSERT: begin
          if (v != 0 && v <= 2 * s) begin
            sd = cur_side;
            // times past the horizon land in the other bitmap
            if (v > s) begin
              v -= s;
              sd ^= 1;
            end
            bits[sd][(v - 1) / 32][(v - 1) % 32] = 1'b1;
            nxt[node_id] = head[sd][v];
            head[sd][v] = {1'b1, node_id};
            count = count + 1'b1;
          end
        end
        KIND_FIND, KIND_PEEK: begin
          if (count == 0) begin
            a.status = 1'b1;
          end else begin
            sd = cur_side;
            wd = cur_word;
            off = offset;
            found = scan_min(sd, wd, off);
            if (found == 0) begin
              a.status = 1'b1;
            end else begin
              a.min_value = MIN_W'(found);
              a.offset = off;
              if (kind == KIND_FIND) begin
                cur_side = sd;
                cur_word = wd;
                offset = off;
                count = count - 1'b1;
                h = head[sd][found];
                // drop the bit once the slot is down to its last node
                if (!h[6] || !nxt[h[5:0]][6]) bits[sd][wd][(found - 1) % 32] = 1'b0;
              end
            end
          end
        end
        default: begin
          if (v == 0 || v > s || !head[cur_side][v][6]) begin
            a.status = 1'b1;
          end else begin
            onode = head[cur_side][v][5:0];
            a.node = onode;
            head[cur_side][v] = nxt[onode];
          end
        end
      endcase
      expected_answers.push_back(a);
    endfunction

    function void check_answer(logic status, logic [MIN_W-1:0] min_value,
                               logic [NODE_W-1:0] node, logic [OFF_W-1:0] offset_in);
      answer_t e;
      if (expected_answers.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      e = expected_answers.pop_front();
      checked++;
      if (e.status) misses++;
      if (status !== e.status) begin
        $error("out_status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (min_value !== e.min_value) begin
        $error("out_min_value: expected %0d, got %0d", e.min_value, min_value);
        errors++;
      end
      if (node !== e.node) begin
        $error("out_node: expected %0d, got %0d", e.node, node);
        errors++;
      end
      if (offset_in !== e.offset) begin
        $error("out_time_offset: expected %0d, got %0d", $signed(e.offset),
               $signed(offset_in));
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_kind;
  logic [VAL_W-1:0]        in_slot_value;
  logic [NODE_W-1:0]       in_node_id;
  logic                    out_valid;
  logic                    out_status;
  logic [MIN_W-1:0]        out_min_value;
  logic [NODE_W-1:0]       out_node;
  logic signed [OFF_W-1:0] out_time_offset;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [1:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  release_queue_scoreboard queue_check;
  int                      cycles = 0;
  int                      cfg_writes = 0;

  bitmap_release_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_slot_value   (in_slot_value),
    .in_node_id      (in_node_id),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_min_value   (out_min_value),
    .out_node        (out_node),
    .out_time_offset (out_time_offset),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_release_queue test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      queue_check.check_answer(out_status, out_min_value, out_node, out_time_offset);
    end
  end

  task automatic send_request(input logic [1:0] kind, input int val, input int node_id);
    start         <= 1'b1;
    in_kind       <= kind;
    in_slot_value <= VAL_W'(val);
    in_node_id    <= NODE_W'(node_id);
    do @(posedge clk); while (busy);
    queue_check.note_request(kind, VAL_W'(val), NODE_W'(node_id));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (queue_check.outstanding() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_words_in_use(input logic [CFG_W-1:0] v);
    logic [31:0] data;
    data = ($urandom() & ~32'h7) | 32'(v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(4 * REG_WORDS_IN_USE);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    queue_check.words_cfg = v;
    cfg_writes++;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(v)) begin
      $error("prdata: expected %0d, got %0d", v, prdata);
      queue_check.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int items, input int insert_pct, input bit gaps);
    int burst_left;
    int r;
    int q;
    int s;
    int val;
    logic [1:0] kind;
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < items; i++) begin
      s = queue_check.span() * 32;
      r = $urandom_range(0, 99);
      q = $urandom_range(0, 19);
      val = 0;
      if (r < insert_pct) begin
        kind = KIND_INSERT;
        if (q == 0) val = 0;
        else if (q == 1) val = $urandom_range(2 * s + 1, 511);
        else if (q == 2) val = 2 * s;
        else val = $urandom_range(1, 2 * s);
      end else begin
        r = $urandom_range(0, 19);
        kind = (r < 8) ? KIND_FIND : (r < 15) ? KIND_POP : KIND_PEEK;
        if (kind == KIND_POP) begin
          if (q < 13) val = queue_check.pick_occupied_slot();
          if (val == 0) val = (q < 17) ? $urandom_range(1, s) : $urandom_range(0, 511);
        end else begin
          val = $urandom_range(0, 511);
        end
      end
      send_request(kind, val, $urandom_range(0, NODES - 1));
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if (gaps) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    queue_check = new();
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_kind       <= KIND_INSERT;
    in_slot_value <= '0;
    in_node_id    <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, bad pops, out-of-range inserts
    send_request(KIND_PEEK, 0, 0);
    send_request(KIND_FIND, 511, 63);
    send_request(KIND_POP, 0, 0);
    send_request(KIND_POP, 200, 0);
    send_request(KIND_POP, 5, 0);
    send_request(KIND_INSERT, 0, 1);
    send_request(KIND_INSERT, 257, 2);
    send_request(KIND_INSERT, 511, 63);
    // both bitmaps, both ends of the horizon, two nodes in one slot
    send_request(KIND_INSERT, 1, 0);
    send_request(KIND_INSERT, 1, 63);
    send_request(KIND_INSERT, 128, 42);
    send_request(KIND_INSERT, 129, 21);
    send_request(KIND_INSERT, 256, 7);
    send_request(KIND_PEEK, 0, 0);
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_POP, 1, 0);
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_POP, 128, 0);
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_FIND, 0, 0);
    // leave a count with no bits set, so the scan runs dry
    send_request(KIND_INSERT, 5, 3);
    send_request(KIND_INSERT, 5, 4);
    send_request(KIND_POP, 5, 0);
    send_request(KIND_POP, 5, 0);
    send_request(KIND_FIND, 0, 0);
    send_request(KIND_PEEK, 0, 0);
    // park the scan on the last word before shrinking the bitmap
    send_request(KIND_INSERT, 100, 9);
    send_request(KIND_FIND, 0, 0);

    set_words_in_use(3'd1);
    run_phase(80, 45, 1'b1);
    set_words_in_use(3'd4);
    run_phase(110, 50, 1'b1);
    set_words_in_use(3'd2);
    run_phase(80, 45, 1'b0);
    set_words_in_use(3'd0);
    run_phase(70, 45, 1'b1);
    set_words_in_use(3'd7);
    run_phase(90, 70, 1'b1);
    set_words_in_use(3'd3);
    run_phase(80, 40, 1'b1);
    set_words_in_use(3'd5);
    run_phase(70, 45, 1'b1);
    set_words_in_use(3'd4);
    run_phase(90, 30, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d inserts, %0d finds, %0d pops, %0d peeks over %0d register settings.",
             queue_check.kind_seen[KIND_INSERT], queue_check.kind_seen[KIND_FIND],
             queue_check.kind_seen[KIND_POP], queue_check.kind_seen[KIND_PEEK], cfg_writes);
    $display("Checked %0d result beats, %0d of them empty-queue or empty-slot answers.",
             queue_check.checked, queue_check.misses);
    if (queue_check.errors == 0 && queue_check.outstanding() == 0) begin
      $display("bitmap_release_queue test passed");
    end else begin
      $display("bitmap_release_queue test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/brq_pkg.sv
design/bitmap_release_queue.sv
dv/tb_bitmap_release_queue.sv
